>>> rtl/ezr_pkg.sv
// Package with the shared constants, types and helper functions of the Euler to matrix block.
package ezr_pkg;

	localparam int AngW        = 32;
	localparam int TableLen    = 30;
	localparam int DefStages   = 24;
	localparam int CordW       = 36;

	localparam logic signed [AngW:0] AngPi     = 33'sd843314857;
	localparam logic signed [AngW:0] AngTwoPi  = 33'sd1686629713;
	localparam logic signed [AngW:0] AngHalfPi = 33'sd421657428;
	localparam logic signed [CordW-1:0] CordGain = 36'sd652032874;

	typedef logic signed [CordW-1:0] cord_t;
	typedef logic signed [31:0] q30_t;

	// Request payload: three angles in signed Q3.28 radians.
	typedef struct packed {
		logic signed [31:0] yaw_angle;
		logic signed [31:0] pitch_angle;
		logic signed [31:0] roll_angle;
	} angles_t;

	// Result payload: nine matrix entries in signed Q2.30, row by row.
	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m20;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
	} matrix_t;

	// Arctangent table in Q2.30.
	function automatic cord_t atan_lookup(input int idx);
		logic [31:0] t;
		case (idx)
			0:  t = 32'h3243F6A8;
			1:  t = 32'h1DAC6705;
			2:  t = 32'h0FADBAFC;
			3:  t = 32'h07F56EA6;
			4:  t = 32'h03FEAB76;
			5:  t = 32'h01FFD55B;
			6:  t = 32'h00FFFAAA;
			7:  t = 32'h007FFF55;
			8:  t = 32'h003FFFEA;
			9:  t = 32'h001FFFFD;
			10: t = 32'h000FFFFF;
			11: t = 32'h0007FFFF;
			12: t = 32'h0003FFFF;
			13: t = 32'h0001FFFF;
			14: t = 32'h0000FFFF;
			15: t = 32'h00007FFF;
			16: t = 32'h00003FFF;
			17: t = 32'h00001FFF;
			18: t = 32'h00000FFF;
			19: t = 32'h000007FF;
			20: t = 32'h000003FF;
			21: t = 32'h000001FF;
			22: t = 32'h000000FF;
			23: t = 32'h0000007F;
			24: t = 32'h0000003F;
			25: t = 32'h0000001F;
			26: t = 32'h0000000F;
			27: t = 32'h00000008;
			28: t = 32'h00000004;
			29: t = 32'h00000002;
			default: t = 32'h0;
		endcase
		return cord_t'({4'b0000, t});
	endfunction

	// Rounded Q2.30 product. Sines, cosines and their products stay within
	// 32 signed bits, so a 32 by 32 multiply suffices.
	function automatic logic signed [39:0] qmul(input logic signed [39:0] a,
		input logic signed [39:0] b);
		logic signed [31:0] a32;
		logic signed [31:0] b32;
		logic signed [63:0] p;
		a32 = $signed(a[31:0]);
		b32 = $signed(b[31:0]);
		p = a32 * b32;
		p = p + 64'sd536870912;
		return 40'(p >>> 30);
	endfunction

	// Saturate to the 32-bit range.
	function automatic q30_t sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -40'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

>>> rtl/ezr_if.sv
// Valid/ready stream interface carrying a generic payload.
interface ezr_if #(
	parameter type payload_t = logic
) (
	input logic clk
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ezr_cordic.sv
// Pipelined angle reduction and CORDIC giving sine and cosine of one angle.
module ezr_cordic
	import ezr_pkg::*;
#(
	parameter int STAGES = DefStages
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [AngW-1:0] angle,
	output cord_t                  sin_out,
	output cord_t                  cos_out
);
	localparam int N = (STAGES < TableLen) ? STAGES : TableLen;

	cord_t x_q [N+1];
	cord_t y_q [N+1];
	cord_t z_q [N+1];
	logic  flip_q [N+1];

	// Reduce into -pi..pi, then fold into -pi/2..pi/2.
	logic signed [AngW:0] a0, a1;
	logic                 fl;
	always_comb begin
		a0 = {angle[AngW-1], angle};
		if (a0 > AngPi)
			a0 = a0 - AngTwoPi;
		else if (a0 < -AngPi)
			a0 = a0 + AngTwoPi;
		fl = 1'b0;
		a1 = a0;
		if (a0 > AngHalfPi) begin
			a1 = a0 - AngPi;
			fl = 1'b1;
		end else if (a0 < -AngHalfPi) begin
			a1 = a0 + AngPi;
			fl = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]    <= CordGain;
			y_q[0]    <= '0;
			z_q[0]    <= cord_t'(a1) <<< 2;
			flip_q[0] <= fl;
		end
	end

	// One micro-rotation per register stage.
	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				flip_q[i+1] <= flip_q[i];
				if (!z_q[i][CordW-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_lookup(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_lookup(i);
				end
			end
		end
	end

	assign sin_out = flip_q[N] ? -y_q[N] : y_q[N];
	assign cos_out = flip_q[N] ? -x_q[N] : x_q[N];
endmodule

>>> rtl/euler_zyx_to_rotation_matrix.sv
// Top level: Euler ZYX angles to a rotation matrix, fully pipelined.
// A new angle triple (yaw, pitch, roll; signed Q3.28 radians) can be taken every cycle
// while the output is not stalled; each request yields one matrix of nine signed Q2.30
// entries. The pipeline has one reduction stage, one stage per CORDIC rotation, then a
// sine/cosine register, two product stages and a sum/saturate stage. The whole pipeline
// advances only when its last stage is empty or its result is being taken, so a stall on
// the output holds every item in place.
module euler_zyx_to_rotation_matrix
	import ezr_pkg::*;
#(
	parameter int CORDIC_STAGES = DefStages
) (
	input logic clk,
	input logic arst_n,
	ezr_if.sink   in_ch,
	ezr_if.source out_ch
);
	localparam int N   = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;
	localparam int LAT = N + 5;

	typedef logic signed [39:0] w_t;

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en          = !vld_q[LAT-1] || out_ch.ready;
	assign in_ch.ready = en;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
	end

	cord_t sz, cz, sy, cy, sx, cx;
	ezr_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .en(en), .angle(in_ch.data.yaw_angle), .sin_out(sz), .cos_out(cz));
	ezr_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .en(en), .angle(in_ch.data.pitch_angle), .sin_out(sy), .cos_out(cy));
	ezr_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .en(en), .angle(in_ch.data.roll_angle), .sin_out(sx), .cos_out(cx));

	// Register sine and cosine values.
	w_t sz_s1, cz_s1, sy_s1, cy_s1, sx_s1, cx_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			sz_s1 <= w_t'(sz); cz_s1 <= w_t'(cz);
			sy_s1 <= w_t'(sy); cy_s1 <= w_t'(cy);
			sx_s1 <= w_t'(sx); cx_s1 <= w_t'(cx);
		end
	end

	// First products.
	w_t czcy_s2, czsy_s2, cxsz_s2, czcx_s2, szsx_s2, cysz_s2, szsy_s2, czsx_s2;
	w_t cysx_s2, cycx_s2, sy_s2, sx_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			czcy_s2 <= qmul(cz_s1, cy_s1);
			czsy_s2 <= qmul(cz_s1, sy_s1);
			cxsz_s2 <= qmul(cx_s1, sz_s1);
			czcx_s2 <= qmul(cz_s1, cx_s1);
			szsx_s2 <= qmul(sz_s1, sx_s1);
			cysz_s2 <= qmul(cy_s1, sz_s1);
			szsy_s2 <= qmul(sz_s1, sy_s1);
			czsx_s2 <= qmul(cz_s1, sx_s1);
			cysx_s2 <= qmul(cy_s1, sx_s1);
			cycx_s2 <= qmul(cy_s1, cx_s1);
			sy_s2   <= sy_s1;
			sx_s2   <= sx_s1;
		end
	end

	// Triple products, pass-through of finished terms.
	w_t t01_s3, t02_s3, t11_s3, t12_s3;
	w_t cxsz_s3, szsx_s3, czcx_s3, czsx_s3, czcy_s3, cysz_s3, cysx_s3, cycx_s3, sy_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			t01_s3  <= qmul(czsy_s2, sx_s2);
			t02_s3  <= qmul(czcx_s2, sy_s2);
			t11_s3  <= qmul(szsy_s2, sx_s2);
			t12_s3  <= qmul(cxsz_s2, sy_s2);
			cxsz_s3 <= cxsz_s2; szsx_s3 <= szsx_s2; czcx_s3 <= czcx_s2;
			czsx_s3 <= czsx_s2; czcy_s3 <= czcy_s2; cysz_s3 <= cysz_s2;
			cysx_s3 <= cysx_s2; cycx_s3 <= cycx_s2; sy_s3 <= sy_s2;
		end
	end

	// Sums and saturation into the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.data.m00 <= sat32(czcy_s3);
			out_ch.data.m01 <= sat32(t01_s3 - cxsz_s3);
			out_ch.data.m02 <= sat32(t02_s3 + szsx_s3);
			out_ch.data.m10 <= sat32(cysz_s3);
			out_ch.data.m11 <= sat32(czcx_s3 + t11_s3);
			out_ch.data.m12 <= sat32(t12_s3 - czsx_s3);
			out_ch.data.m20 <= sat32(-sy_s3);
			out_ch.data.m21 <= sat32(cysx_s3);
			out_ch.data.m22 <= sat32(cycx_s3);
		end
	end

	assign out_ch.valid = vld_q[LAT-1];
endmodule

>>> rtl/ezr_checker.sv
// Port-level checker for the Euler to matrix block, with its bind.
module ezr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	// A result waiting on a stalled sink stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// The input is blocked only while a result waits.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked without a stall");

	// When the sink takes results, the input is open.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input not ready while output drains");
endmodule

bind euler_zyx_to_rotation_matrix ezr_checker u_ezr_checker (
	.clk(clk), .arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready));

>>> tb/tb_euler_zyx_to_rotation_matrix.sv
// Testbench for the Euler ZYX angle to rotation matrix block: directed, random and stall tests.
module tb_euler_zyx_to_rotation_matrix;
	import ezr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Stages  = DefStages;
	localparam int Latency = ((Stages < TableLen) ? Stages : TableLen) + 5;
	localparam int HoldCycles = 150;

	localparam logic signed [31:0] Pi     = 32'sd843314857;
	localparam logic signed [31:0] HalfPi = 32'sd421657428;

	logic clk;
	logic arst_n;

	ezr_if #(.payload_t(angles_t)) in_ch (.clk(clk));
	ezr_if #(.payload_t(matrix_t)) out_ch (.clk(clk));

	euler_zyx_to_rotation_matrix #(.CORDIC_STAGES(Stages)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Arctangent steps of the rotation, Q2.30.
	localparam longint ArcSteps[30] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
	};

	matrix_t matrix_queue[$];
	int      mismatches = 0;
	int      send_idle;
	int      recv_idle;
	logic    hold_off;
	event    hold_go;

	// Clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Sine and cosine of one angle: wrap, fold, then iterate the rotation.
	task automatic angle_sin_cos(input logic signed [31:0] ang, output longint s,
		output longint c);
		longint a, x, y, z, dx, dy;
		bit     flip;
		a = ang;
		flip = 0;
		if (a > 843314857)
			a -= 1686629713;
		else if (a < -843314857)
			a += 1686629713;
		if (a > 421657428) begin
			a -= 843314857;
			flip = 1;
		end else if (a < -421657428) begin
			a += 843314857;
			flip = 1;
		end
		z = a * 4;
		x = 652032874;
		y = 0;
		for (int i = 0; i < Stages && i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ArcSteps[i];
			end else begin
				x += dx;
				y -= dy;
				z += ArcSteps[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	function automatic longint fix_mul(input longint a, input longint b);
		return (a * b + 64'sd536870912) >>> 30;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// Expected rotation matrix for one angle triple.
	task automatic rotation_of(input angles_t ang, output matrix_t m);
		longint sz, cz, sy, cy, sx, cx;
		angle_sin_cos(ang.yaw_angle, sz, cz);
		angle_sin_cos(ang.pitch_angle, sy, cy);
		angle_sin_cos(ang.roll_angle, sx, cx);
		m.m00 = clamp32(fix_mul(cz, cy));
		m.m01 = clamp32(fix_mul(fix_mul(cz, sy), sx) - fix_mul(cx, sz));
		m.m02 = clamp32(fix_mul(fix_mul(cz, cx), sy) + fix_mul(sz, sx));
		m.m10 = clamp32(fix_mul(cy, sz));
		m.m11 = clamp32(fix_mul(cz, cx) + fix_mul(fix_mul(sz, sy), sx));
		m.m12 = clamp32(fix_mul(fix_mul(cx, sz), sy) - fix_mul(cz, sx));
		m.m20 = clamp32(-sy);
		m.m21 = clamp32(fix_mul(cy, sx));
		m.m22 = clamp32(fix_mul(cy, cx));
	endtask

	// Send one request, idling at random first; the prediction is queued on acceptance.
	task automatic send_request(input logic signed [31:0] yaw, input logic signed [31:0] pitch,
		input logic signed [31:0] roll);
		angles_t ang;
		matrix_t m;
		ang = '{yaw, pitch, roll};
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= ang;
		do
			@(posedge clk);
		while (!in_ch.ready);
		rotation_of(ang, m);
		matrix_queue.push_back(m);
	endtask

	function automatic logic signed [31:0] any_angle();
		return $urandom;
	endfunction

	// Mostly angles within one turn, with some full-range values.
	function automatic logic signed [31:0] pick_angle();
		if ($urandom_range(3) == 0)
			return $urandom;
		return $signed($urandom_range(2 * 843314857 + 200)) - 843314857 - 100;
	endfunction

	// Long receiver hold-off, counted in cycles once triggered.
	initial begin
		hold_off = 1'b0;
		forever begin
			@(hold_go);
			hold_off <= 1'b1;
			repeat (HoldCycles) @(posedge clk);
			hold_off <= 1'b0;
		end
	end

	// Receiver: random stalls, long hold-offs, and the result check.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (matrix_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected matrix %h", out_ch.data);
				end else begin
					matrix_t want;
					want = matrix_queue.pop_front();
					if (out_ch.data !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Matrix mismatch: expected %h, got %h", want,
								out_ch.data);
					end
				end
			end
			if (hold_off)
				out_ch.ready <= 1'b0;
			else
				out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Extremes, wrap and fold boundaries.
	task automatic test_directed();
		logic signed [31:0] edges[12];
		edges = '{32'sd0, 32'sh7FFFFFFF, 32'sh80000000, Pi, Pi + 1, -Pi, -Pi - 1,
			HalfPi, HalfPi + 1, -HalfPi, -HalfPi - 1, 32'sd1};
		foreach (edges[i])
			send_request(edges[i], edges[(i + 5) % 12], edges[(i + 9) % 12]);
		send_request(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_request(32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_request(0, HalfPi, 0);
		send_request(0, -HalfPi, Pi);
		send_request(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_request(pick_angle(), pick_angle(), pick_angle());
	endtask

	// Long output hold-off while requests keep coming, so the input stalls.
	task automatic test_backpressure();
		-> hold_go;
		for (int i = 0; i < 60; i++)
			send_request(any_angle(), any_angle(), any_angle());
	endtask

	// Sender waits until every pending matrix has arrived, then resumes.
	task automatic test_drain();
		in_ch.valid <= 1'b0;
		wait (matrix_queue.size() == 0);
		@(posedge clk);
		test_random(10);
	endtask

	initial begin
		send_idle   = 16;
		recv_idle   = 70;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(110);
		test_drain();
		send_idle = 70;
		recv_idle = 16;
		test_random(100);
		test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		test_random(100);
		in_ch.valid <= 1'b0;
		wait (matrix_queue.size() == 0);
		repeat (Latency + 10) @(posedge clk);
		if (mismatches == 0 && matrix_queue.size() == 0)
			$display("euler_zyx_to_rotation_matrix verification clean");
		else
			$display("euler_zyx_to_rotation_matrix verification failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#2ms;
		$display("euler_zyx_to_rotation_matrix verification failed");
		$finish;
	end

endmodule
